>>> hdl/prom_pkg.sv
package prom_pkg;

   localparam int unsigned TimeWidth = 63;
   localparam int unsigned CntWidth  = 32;
   localparam int unsigned QuoWidth  = 63;

   localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};
   localparam logic [CntWidth-1:0]  CntMax  = {CntWidth{1'b1}};
   localparam logic [CntWidth-1:0]  PeriodReset = 32'd1000000;

   typedef enum logic [1:0] {
      OP_RELEASE = 2'd0,
      OP_WAKE    = 2'd1,
      OP_FINISH  = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FAIL    = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REL_ADD,
      S_REL_CHK,
      S_REL_DIV1,
      S_REL_DIV2,
      S_REL_APPLY,
      S_FIN_DIV,
      S_FIN_APPLY,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [TimeWidth-1:0] time_ns;
      logic                 sleep_failed;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [TimeWidth-1:0] deadline_ns;
      logic [CntWidth-1:0]  sequence_res;
      logic [CntWidth-1:0]  skipped_total;
      logic [CntWidth-1:0]  misses_total;
      logic [CntWidth-1:0]  sleep_fail_total;
      logic [TimeWidth-1:0] actual_period;
      logic [TimeWidth-1:0] wake_lag;
      logic [TimeWidth-1:0] wake_lag_peak;
      logic [TimeWidth-1:0] exec_time;
      logic [TimeWidth-1:0] exec_time_peak;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   // saturating counter add, wide increment
   function automatic logic [CntWidth-1:0] cnt_add(input logic [CntWidth-1:0] c,
                                                   input logic [QuoWidth:0] inc);
      logic [QuoWidth+1:0] s;
      s = {{(QuoWidth+2-CntWidth){1'b0}}, c} + {1'b0, inc};
      if (s >= {{(QuoWidth+2-CntWidth){1'b0}}, CntMax}) return CntMax;
      return s[CntWidth-1:0];
   endfunction

endpackage

>>> hdl/prom_if.sv
interface prom_req_if;
   logic              valid;
   logic              ready;
   prom_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface prom_rsp_if;
   logic              valid;
   logic              ready;
   prom_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/prom_div.sv
// restoring divider, one quotient bit per cycle
module prom_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [prom_pkg::TimeWidth-1:0]      dividend,
   input  logic [prom_pkg::CntWidth-1:0]       divisor,
   output prom_pkg::div_ctl_type               ctl,
   output logic [prom_pkg::QuoWidth-1:0]       quotient,
   output logic [prom_pkg::CntWidth-1:0]       remainder
);
   localparam int unsigned CntBits = $clog2(prom_pkg::TimeWidth + 1);

   logic [prom_pkg::TimeWidth-1:0] quo_ff, quo_in;
   logic [prom_pkg::CntWidth:0]    rem_ff, rem_in;
   logic [prom_pkg::CntWidth-1:0]  dvs_ff, dvs_in;
   logic [CntBits-1:0]             cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [prom_pkg::CntWidth:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[prom_pkg::CntWidth-1:0], quo_ff[prom_pkg::TimeWidth-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CntBits'(prom_pkg::TimeWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[prom_pkg::TimeWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[prom_pkg::TimeWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[prom_pkg::CntWidth-1:0];
endmodule

>>> hdl/periodic_release_overrun_monitor.sv
// periodic release monitor with overrun accounting
// req channel: one word per event (opcode, time_ns, sleep_failed); rsp channel:
// one word per event with the schedule and all statistics after that event.
// csr port: csr_we with csr_wdata writes period_ns; write only while idle.
// one event is worked at a time; req ready is low from acceptance until the
// response word is loaded into the output register, and a new word can be
// taken on the next edge. a wake, a clear, an ignored event or a finish
// with no miss goes from acceptance to the output state; a release runs
// through the add and check states, and when whole periods are skipped
// through two divisions on the shared bit-serial divider and an apply
// state; a finish past the next deadline makes one division. reset clears
// the schedule and sets the period to 1000000; while rsp ready is low the
// response register holds its word and the next finished event waits for it.
module periodic_release_overrun_monitor (
   input  logic                          clock,
   input  logic                          reset,
   prom_req_if.sink                      req,
   prom_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  logic [prom_pkg::CntWidth-1:0] csr_wdata
);
   localparam int unsigned TW = prom_pkg::TimeWidth;
   localparam int unsigned CW = prom_pkg::CntWidth;

   prom_pkg::state_type state_ff, state_in;
   logic [CW-1:0] period_ff;

   logic [TW-1:0] dl_ff, dl_in, prev_ff, prev_in, cur_ff, cur_in;
   logic          run_ff, run_in;
   logic [CW-1:0] cyc_ff, cyc_in, skip_ff, skip_in, miss_ff, miss_in, fail_ff, fail_in;
   logic [TW-1:0] pseen_ff, pseen_in, lat_ff, lat_in, latpk_ff, latpk_in;
   logic [TW-1:0] exe_ff, exe_in, exepk_ff, exepk_in;

   prom_pkg::req_type req_ff, req_in;
   logic [1:0]        st_ff, st_in;
   logic              up_ff, up_in;
   logic [TW-1:0]     q1_ff, q1_in, nr_ff, nr_in;

   logic              div_start;
   logic [TW-1:0]     div_dividend;
   prom_pkg::div_ctl_type div_ctl;
   logic [prom_pkg::QuoWidth-1:0] div_q;
   logic [CW-1:0]     div_rem;

   logic              rsp_valid_ff, rsp_valid_in;
   prom_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] p_eff;
   logic [TW:0]   sum_w;
   logic [TW-1:0] sum_sat;
   logic [TW-1:0] add_a;

   prom_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (p_eff),
      .ctl       (div_ctl),
      .quotient  (div_q),
      .remainder (div_rem)
   );

   assign p_eff = (period_ff == '0) ? CW'(1) : period_ff;

   // shared saturating time adder
   assign sum_w   = {1'b0, add_a} + {{(TW+1-CW){1'b0}}, p_eff};
   assign sum_sat = sum_w[TW] ? prom_pkg::TimeMax : sum_w[TW-1:0];

   always_comb begin
      state_in = state_ff;
      dl_in = dl_ff; prev_in = prev_ff; cur_in = cur_ff; run_in = run_ff;
      cyc_in = cyc_ff; skip_in = skip_ff; miss_in = miss_ff; fail_in = fail_ff;
      pseen_in = pseen_ff; lat_in = lat_ff; latpk_in = latpk_ff;
      exe_in = exe_ff; exepk_in = exepk_ff;
      req_in = req_ff; st_in = st_ff; up_in = up_ff; q1_in = q1_ff; nr_in = nr_ff;
      div_start = 1'b0;
      div_dividend = '0;
      add_a = run_ff ? dl_ff : req_ff.time_ns;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         prom_pkg::S_IDLE: begin
            if (req.valid) begin
               req_in = req.payload;
               st_in  = prom_pkg::ST_OK;
               up_in  = 1'b0;
               state_in = prom_pkg::S_OUT;
               case (prom_pkg::opcode_type'(req.payload.opcode))
                  prom_pkg::OP_RELEASE: begin
                     up_in = 1'b1;
                     state_in = prom_pkg::S_REL_ADD;
                  end
                  prom_pkg::OP_WAKE: begin
                     if (!run_ff) begin
                        st_in = prom_pkg::ST_IGNORED; up_in = 1'b1;
                     end else if (req.payload.sleep_failed) begin
                        fail_in = prom_pkg::cnt_add(fail_ff, 64'd1);
                        st_in = prom_pkg::ST_FAIL; up_in = 1'b1;
                     end else begin
                        if (cyc_ff != '0)
                           pseen_in = (req.payload.time_ns > prev_ff) ?
                                      req.payload.time_ns - prev_ff : '0;
                        prev_in = req.payload.time_ns;
                        cur_in  = req.payload.time_ns;
                        lat_in  = (req.payload.time_ns > dl_ff) ?
                                  req.payload.time_ns - dl_ff : '0;
                        if (lat_in > latpk_ff) latpk_in = lat_in;
                        cyc_in = prom_pkg::cnt_add(cyc_ff, 64'd1);
                     end
                  end
                  prom_pkg::OP_FINISH: begin
                     if (!run_ff) begin
                        st_in = prom_pkg::ST_IGNORED; up_in = 1'b1;
                     end else begin
                        exe_in = (req.payload.time_ns > cur_ff) ?
                                 req.payload.time_ns - cur_ff : '0;
                        if (exe_in > exepk_ff) exepk_in = exe_in;
                        add_a = dl_ff;
                        nr_in = sum_sat;
                        if (req.payload.time_ns > sum_sat) begin
                           div_start = 1'b1;
                           div_dividend = req.payload.time_ns - sum_sat;
                           state_in = prom_pkg::S_FIN_DIV;
                        end
                     end
                  end
                  default: begin
                     dl_in = '0; prev_in = '0; cur_in = '0; run_in = 1'b0;
                     cyc_in = '0; skip_in = '0; miss_in = '0; fail_in = '0;
                     pseen_in = '0; lat_in = '0; latpk_in = '0;
                     exe_in = '0; exepk_in = '0;
                  end
               endcase
            end
         end
         prom_pkg::S_REL_ADD: begin
            dl_in = sum_sat;
            run_in = 1'b1;
            state_in = prom_pkg::S_REL_CHK;
         end
         prom_pkg::S_REL_CHK: begin
            if (dl_ff <= req_ff.time_ns) begin
               div_start = 1'b1;
               div_dividend = req_ff.time_ns - dl_ff;
               state_in = prom_pkg::S_REL_DIV1;
            end else begin
               state_in = prom_pkg::S_OUT;
            end
         end
         prom_pkg::S_REL_DIV1: begin
            if (div_ctl.done) begin
               q1_in = div_q;
               // unclipped skip lands one period past the event time, less the remainder
               nr_in = req_ff.time_ns - TW'(div_rem) + TW'(p_eff);
               div_start = 1'b1;
               div_dividend = prom_pkg::TimeMax - dl_ff;
               state_in = prom_pkg::S_REL_DIV2;
            end
         end
         prom_pkg::S_REL_DIV2: begin
            if (div_ctl.done) begin
               // clipped skip stops at the last whole period at or below the top of time
               if (!(q1_ff < div_q)) nr_in = prom_pkg::TimeMax - TW'(div_rem);
               skip_in = prom_pkg::cnt_add(skip_ff, {1'b0, q1_ff} + 64'd1);
               state_in = prom_pkg::S_REL_APPLY;
            end
         end
         prom_pkg::S_REL_APPLY: begin
            dl_in = nr_ff;
            state_in = prom_pkg::S_OUT;
         end
         prom_pkg::S_FIN_DIV: begin
            if (div_ctl.done) begin
               miss_in = prom_pkg::cnt_add(miss_ff, {1'b0, div_q} + 64'd1);
               state_in = prom_pkg::S_OUT;
            end
         end
         prom_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = st_ff;
               rsp_in.deadline_ns = dl_ff;
               rsp_in.sequence_res = up_ff ? prom_pkg::cnt_add(cyc_ff, 64'd1) : cyc_ff;
               rsp_in.skipped_total = skip_ff;
               rsp_in.misses_total = miss_ff;
               rsp_in.sleep_fail_total = fail_ff;
               rsp_in.actual_period = pseen_ff;
               rsp_in.wake_lag = lat_ff;
               rsp_in.wake_lag_peak = latpk_ff;
               rsp_in.exec_time = exe_ff;
               rsp_in.exec_time_peak = exepk_ff;
               state_in = prom_pkg::S_IDLE;
            end
         end
         default: state_in = prom_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; st_ff <= st_in; up_ff <= up_in; q1_ff <= q1_in; nr_ff <= nr_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= prom_pkg::S_IDLE;
         period_ff <= prom_pkg::PeriodReset;
         rsp_valid_ff <= 1'b0;
         run_ff <= 1'b0;
         dl_ff <= '0; prev_ff <= '0; cur_ff <= '0;
         cyc_ff <= '0; skip_ff <= '0; miss_ff <= '0; fail_ff <= '0;
         pseen_ff <= '0; lat_ff <= '0; latpk_ff <= '0; exe_ff <= '0; exepk_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         run_ff <= run_in;
         dl_ff <= dl_in; prev_ff <= prev_in; cur_ff <= cur_in;
         cyc_ff <= cyc_in; skip_ff <= skip_in; miss_ff <= miss_in; fail_ff <= fail_in;
         pseen_ff <= pseen_in; lat_ff <= lat_in; latpk_ff <= latpk_in;
         exe_ff <= exe_in; exepk_ff <= exepk_in;
         if (csr_we) period_ff <= csr_wdata;
      end
   end

   assign req.ready   = (state_ff == prom_pkg::S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_peak_lat: assert property (@(posedge clock) disable iff (reset)
      latpk_ff >= lat_ff) else $error("latency peak below last latency");
   a_peak_exe: assert property (@(posedge clock) disable iff (reset)
      exepk_ff >= exe_ff) else $error("exec peak below last exec time");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.busy |-> (state_ff == prom_pkg::S_REL_DIV1 ||
                        state_ff == prom_pkg::S_REL_DIV2 ||
                        state_ff == prom_pkg::S_FIN_DIV))
      else $error("divider busy outside a divide state");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response word dropped while stalled");
endmodule
